[rtl/core/ntt_tw_pkg.sv]
package ntt_tw_pkg;

	localparam logic [1:0] OP_FWD  = 2'd0;
	localparam logic [1:0] OP_INV  = 2'd1;
	localparam logic [1:0] OP_NINV = 2'd2;
	localparam logic [1:0] OP_RSVD = 2'd3;

	localparam logic [1:0] REG_MODULUS = 2'd0;
	localparam logic [1:0] REG_ROOT    = 2'd1;
	localparam logic [1:0] REG_LOG     = 2'd2;

	localparam logic [63:0] MODULUS_RST = 64'd3;
	localparam logic [63:0] ROOT_RST    = 64'd1;

	localparam logic [3:0] CMD_NOP         = 4'd0;
	localparam logic [3:0] CMD_LATCH       = 4'd1;
	localparam logic [3:0] CMD_ZERO        = 4'd2;
	localparam logic [3:0] CMD_LD_RED_ROOT = 4'd3;
	localparam logic [3:0] CMD_LD_RED_N    = 4'd4;
	localparam logic [3:0] CMD_LD_MUL      = 4'd5;
	localparam logic [3:0] CMD_LD_SQ       = 4'd6;
	localparam logic [3:0] CMD_MSTEP       = 4'd7;
	localparam logic [3:0] CMD_WB_BASE_QM2 = 4'd8;
	localparam logic [3:0] CMD_WB_BASE_REV = 4'd9;
	localparam logic [3:0] CMD_WB_ACC      = 4'd10;
	localparam logic [3:0] CMD_WB_SQ       = 4'd11;
	localparam logic [3:0] CMD_INV_NEXT    = 4'd12;
	localparam logic [3:0] CMD_LD_DIV      = 4'd13;
	localparam logic [3:0] CMD_DSTEP       = 4'd14;
	localparam logic [3:0] CMD_OUT         = 4'd15;

	typedef struct packed {
		logic [3:0] cmd;
	} dp_cmd_t;

	typedef struct packed {
		logic q_small;
		logic cnt_last;
		logic exp_zero;
		logic exp_lsb;
	} dp_stat_t;

	// x + y mod q for x, y below q
	function automatic logic [63:0] add_mod(input logic [63:0] x, input logic [63:0] y,
		input logic [63:0] q);
		logic [64:0] s;
		begin
			s = {1'b0, x} + {1'b0, y};
			if (s[64] || s[63:0] >= q) begin
				s[63:0] = s[63:0] - q;
			end
			return s[63:0];
		end
	endfunction

endpackage

[rtl/core/ntt_tw_ctrl.sv]
module ntt_tw_ctrl
	import ntt_tw_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] in_opcode,
	output logic       out_valid,
	input  logic       out_ready,
	output dp_cmd_t    dp_cmd,
	input  dp_stat_t   dp_stat
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DEC  = 3'd1;
	localparam logic [2:0] S_MUL  = 3'd2;
	localparam logic [2:0] S_WB   = 3'd3;
	localparam logic [2:0] S_PCHK = 3'd4;
	localparam logic [2:0] S_DIV  = 3'd5;
	localparam logic [2:0] S_OUT  = 3'd6;

	localparam logic [1:0] PH_RED = 2'd0;
	localparam logic [1:0] PH_INV = 2'd1;
	localparam logic [1:0] PH_FIN = 2'd2;

	logic [2:0] state_q, state_d;
	logic [1:0] op_q, op_d;
	logic [1:0] phase_q, phase_d;
	logic       sq_q, sq_d;
	logic       ov_q, ov_d;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = ov_q;

	always_comb begin
		state_d    = state_q;
		op_d       = op_q;
		phase_d    = phase_q;
		sq_d       = sq_q;
		ov_d       = ov_q;
		dp_cmd.cmd = CMD_NOP;
		if (ov_q && out_ready) begin
			ov_d = 1'b0;
		end
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					dp_cmd.cmd = CMD_LATCH;
					op_d       = in_opcode;
					state_d    = S_DEC;
				end
			end
			S_DEC: begin
				phase_d = PH_RED;
				if (dp_stat.q_small || (op_q != OP_FWD && op_q != OP_INV && op_q != OP_NINV)) begin
					dp_cmd.cmd = CMD_ZERO;
					state_d    = S_OUT;
				end else if (op_q == OP_NINV) begin
					dp_cmd.cmd = CMD_LD_RED_N;
					state_d    = S_MUL;
				end else begin
					dp_cmd.cmd = CMD_LD_RED_ROOT;
					state_d    = S_MUL;
				end
			end
			S_MUL: begin
				dp_cmd.cmd = CMD_MSTEP;
				if (dp_stat.cnt_last) begin
					state_d = S_WB;
				end
			end
			S_WB: begin
				if (phase_q == PH_RED) begin
					dp_cmd.cmd = (op_q == OP_FWD) ? CMD_WB_BASE_REV : CMD_WB_BASE_QM2;
					phase_d    = (op_q == OP_INV) ? PH_INV : PH_FIN;
					state_d    = S_PCHK;
				end else if (!sq_q) begin
					// multiply done, square next
					dp_cmd.cmd = CMD_WB_ACC;
					sq_d       = 1'b1;
					state_d    = S_MUL;
				end else begin
					dp_cmd.cmd = CMD_WB_SQ;
					state_d    = S_PCHK;
				end
			end
			S_PCHK: begin
				if (dp_stat.exp_zero) begin
					if (phase_q == PH_INV) begin
						dp_cmd.cmd = CMD_INV_NEXT;
						phase_d    = PH_FIN;
					end else begin
						dp_cmd.cmd = CMD_LD_DIV;
						state_d    = S_DIV;
					end
				end else if (dp_stat.exp_lsb) begin
					dp_cmd.cmd = CMD_LD_MUL;
					sq_d       = 1'b0;
					state_d    = S_MUL;
				end else begin
					dp_cmd.cmd = CMD_LD_SQ;
					sq_d       = 1'b1;
					state_d    = S_MUL;
				end
			end
			S_DIV: begin
				dp_cmd.cmd = CMD_DSTEP;
				if (dp_stat.cnt_last) begin
					state_d = S_OUT;
				end
			end
			S_OUT: begin
				if (!ov_q || out_ready) begin
					dp_cmd.cmd = CMD_OUT;
					ov_d       = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= OP_FWD;
			phase_q <= PH_RED;
			sq_q    <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
			phase_q <= phase_d;
			sq_q    <= sq_d;
			ov_q    <= ov_d;
		end
	end

endmodule

[rtl/core/ntt_tw_dp.sv]
module ntt_tw_dp
	import ntt_tw_pkg::*;
#(
	parameter int MAX_LOG_N = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [63:0] cfg_data,
	input  logic [15:0] in_index,
	input  dp_cmd_t     dp_cmd,
	output dp_stat_t    dp_stat,
	output logic [63:0] out_value,
	output logic [63:0] out_shoup
);

	localparam logic [4:0] LOG_CAP = 5'(MAX_LOG_N);

	logic [63:0] modulus_q, root_q;
	logic [4:0]  log_size_q;
	logic [15:0] idx_q;
	logic [63:0] acc_q, base_q, exp_q, mx_q, my_q, mr_q, rem_q, quo_q;
	logic [5:0]  cnt_q;
	logic [63:0] val_q, sh_q;

	logic [4:0]  lg;
	logic [63:0] rev, n_val, qm2, mr_dbl, mr_next, rem_sh;
	logic        rem_sub;

	assign lg  = (log_size_q > LOG_CAP) ? LOG_CAP : log_size_q;
	assign qm2 = modulus_q - 64'd2;

	always_comb begin
		int k;
		rev = '0;
		for (int j = 0; j < MAX_LOG_N; j++) begin
			k = int'(lg) - 1 - j;
			if (k >= 0 && k < 16) begin
				rev[j] = idx_q[k[3:0]];
			end
		end
	end

	assign n_val = 64'd1 << lg;

	// one step of shift-and-add modular multiply, multiplier msb first
	assign mr_dbl  = add_mod(mr_q, mr_q, modulus_q);
	assign mr_next = my_q[63] ? add_mod(mr_dbl, mx_q, modulus_q) : mr_dbl;

	// one step of restoring division of rem * 2^64 by q
	assign rem_sh  = {rem_q[62:0], 1'b0};
	assign rem_sub = rem_q[63] || (rem_sh >= modulus_q);

	assign dp_stat.q_small  = (modulus_q < 64'd2);
	assign dp_stat.cnt_last = (cnt_q == 6'h3f);
	assign dp_stat.exp_zero = (exp_q == '0);
	assign dp_stat.exp_lsb  = exp_q[0];

	assign out_value = val_q;
	assign out_shoup = sh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q  <= MODULUS_RST;
			root_q     <= ROOT_RST;
			log_size_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_MODULUS: modulus_q  <= cfg_data;
				REG_ROOT:    root_q     <= cfg_data;
				REG_LOG:     log_size_q <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (dp_cmd.cmd)
			CMD_LATCH: idx_q <= in_index;
			CMD_ZERO: begin
				acc_q <= '0;
				quo_q <= '0;
			end
			CMD_LD_RED_ROOT: begin
				mx_q  <= 64'd1;
				my_q  <= root_q;
				mr_q  <= '0;
				cnt_q <= '0;
			end
			CMD_LD_RED_N: begin
				mx_q  <= 64'd1;
				my_q  <= n_val;
				mr_q  <= '0;
				cnt_q <= '0;
			end
			CMD_LD_MUL: begin
				mx_q  <= acc_q;
				my_q  <= base_q;
				mr_q  <= '0;
				cnt_q <= '0;
			end
			CMD_LD_SQ: begin
				mx_q  <= base_q;
				my_q  <= base_q;
				mr_q  <= '0;
				cnt_q <= '0;
			end
			CMD_MSTEP: begin
				mr_q  <= mr_next;
				my_q  <= {my_q[62:0], 1'b0};
				cnt_q <= cnt_q + 6'd1;
			end
			CMD_WB_BASE_QM2: begin
				base_q <= mr_q;
				acc_q  <= 64'd1;
				exp_q  <= qm2;
			end
			CMD_WB_BASE_REV: begin
				base_q <= mr_q;
				acc_q  <= 64'd1;
				exp_q  <= rev;
			end
			CMD_WB_ACC: begin
				acc_q <= mr_q;
				mx_q  <= base_q;
				my_q  <= base_q;
				mr_q  <= '0;
				cnt_q <= '0;
			end
			CMD_WB_SQ: begin
				base_q <= mr_q;
				exp_q  <= {1'b0, exp_q[63:1]};
			end
			CMD_INV_NEXT: begin
				base_q <= acc_q;
				acc_q  <= 64'd1;
				exp_q  <= rev;
			end
			CMD_LD_DIV: begin
				rem_q <= acc_q;
				quo_q <= '0;
				cnt_q <= '0;
			end
			CMD_DSTEP: begin
				rem_q <= rem_sub ? (rem_sh - modulus_q) : rem_sh;
				quo_q <= {quo_q[62:0], rem_sub};
				cnt_q <= cnt_q + 6'd1;
			end
			CMD_OUT: begin
				val_q <= acc_q;
				sh_q  <= quo_q;
			end
			default: ;
		endcase
	end

endmodule

[rtl/core/ntt_twiddle_shoup_generator_unit.sv]
// Returns one NTT root-table entry and its Shoup constant floor(value*2^64/q) per request:
// opcode 0 gives root^bitrev(index) mod q, opcode 1 the same with root^(q-2), opcode 2
// n^(q-2) mod q; opcode 3 or a modulus below two gives zeros. One request is worked at a
// time on a single shift-and-add modular multiplier that retires one multiplier bit per
// cycle, with a writeback after each product. The base is first reduced mod q, then each
// exponent bit takes a square, preceded by a multiply into the accumulator when the bit is
// set; the Shoup constant then comes from a bit-serial restoring division.
// The next request is taken while the previous result waits at the output.
module ntt_twiddle_shoup_generator_unit
	import ntt_tw_pkg::*;
#(
	parameter int MAX_LOG_N = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [23:0]  s_axis_tdata,  // opcode[1:0], entry_index[17:2], zero pad
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [127:0] m_axis_tdata,  // value[63:0], shoup_factor[127:64]
	input  logic         cfg_we,
	input  logic [1:0]   cfg_addr,
	input  logic [63:0]  cfg_data
);

	dp_cmd_t  dp_cmd;
	dp_stat_t dp_stat;
	logic [63:0] value, shoup_factor;

	ntt_tw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_opcode (s_axis_tdata[1:0]),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.dp_cmd    (dp_cmd),
		.dp_stat   (dp_stat)
	);

	ntt_tw_dp #(
		.MAX_LOG_N (MAX_LOG_N)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_data  (cfg_data),
		.in_index  (s_axis_tdata[17:2]),
		.dp_cmd    (dp_cmd),
		.dp_stat   (dp_stat),
		.out_value (value),
		.out_shoup (shoup_factor)
	);

	assign m_axis_tdata = {shoup_factor, value};

endmodule

[rtl/core/ntt_tw_checker.sv]
module ntt_tw_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tvalid,
	input logic         s_axis_tready,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [127:0] m_axis_tdata
);

	// one item in flight: no second item right after an accept
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("item accepted back to back");

	// a zero residue has a zero shoup constant
	a_zero_shoup: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[63:0] == 64'd0) |-> (m_axis_tdata[127:64] == 64'd0))
		else $error("nonzero shoup constant for zero value");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed");

endmodule

bind ntt_twiddle_shoup_generator_unit ntt_tw_checker u_ntt_tw_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
